FILE: design/assert_macros.svh
// Assertion macros shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Checked property, ignored while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checked property, ignored while reset is asserted, for an implication.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: design/bbrm_pkg.sv
// Types and codes of the buddy block release and merge unit.
package bbrm_pkg;

    localparam int ORDER_W = 5;
    localparam int START_W = 16;

    typedef logic [1:0] t_op;
    typedef logic [1:0] t_status;

    localparam t_op OP_LOAD    = 2'd0;
    localparam t_op OP_RELEASE = 2'd1;
    localparam t_op OP_QUERY   = 2'd2;

    localparam t_status ST_OK   = 2'd0;
    localparam t_status ST_BAD  = 2'd1;
    localparam t_status ST_FREE = 2'd2;

endpackage

FILE: design/bbrm_if.sv
// Request and response channel interfaces of the buddy block release and merge unit.
interface bbrm_req_if import bbrm_pkg::*; ();
    logic                 valid;
    logic                 ready;
    t_op                  operation;
    logic [ORDER_W-1:0]   order;
    logic [START_W-1:0]   start_address;

    modport source(output valid, output operation, output order, output start_address,
                   input ready);
    modport sink(input valid, input operation, input order, input start_address,
                 output ready);
endinterface

interface bbrm_rsp_if import bbrm_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [ORDER_W-1:0]   final_order;
    logic [START_W-1:0]   final_start;
    logic                 block_free;
    t_status              status;

    modport source(output valid, output final_order, output final_start,
                   output block_free, output status, input ready);
    modport sink(input valid, input final_order, input final_start,
                 input block_free, input status, output ready);
endinterface

FILE: design/bbrm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bbrm_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/buddy_block_release_merge.sv
// Top level of the buddy block release and merge unit.
// Keeps a buddy allocator's free map, one bit per aligned block of each order from 1 to
// the top order (the smaller of MAX_ORDER and ADDR_BITS), in a 2^ADDR_BITS x 1 RAM.
// After reset the unit clears that RAM one entry per cycle and accepts no request until
// it is done. Every request then makes exactly one response. One request is worked at a
// time; all free map reads and writes go through the single RAM port pair and one shared
// index shifter, so the time per request is set by the RAM read latency. An accepted
// request is checked first, and a rejected block goes straight to the response; a query
// or a block already free is answered once its own bit is read, and a load then marks
// that bit. A release probes each buddy in turn, clearing a free buddy and climbing one
// order, until a buddy is not free or the top order is reached, and then marks the merged
// block. The next request is taken only once the response has been accepted. Ready is
// high only while idle.
`include "assert_macros.svh"

module buddy_block_release_merge import bbrm_pkg::*; #(
    parameter int MAX_ORDER = 16,
    parameter int ADDR_BITS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    bbrm_req_if.sink   i_req,
    bbrm_rsp_if.source o_rsp
);

    localparam int TOP_ORDER = (MAX_ORDER < ADDR_BITS) ? MAX_ORDER : ADDR_BITS;
    localparam int AW        = (ADDR_BITS > START_W) ? ADDR_BITS : START_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_OWN,
        S_PROBE,
        S_BUD,
        S_MARK,
        S_OUT
    } t_state;

    t_state               r_state;
    logic [ADDR_BITS-1:0] r_clr_cnt;
    t_op                  r_op;
    logic [ORDER_W-1:0]   r_order;
    logic [AW-1:0]        r_addr;
    logic                 r_bf;
    t_status              r_status;

    logic [AW-1:0]        w_bit;
    logic [AW-1:0]        w_buddy;
    logic [AW-1:0]        w_sel_addr;
    logic [ADDR_BITS-1:0] w_map_idx;
    logic                 w_ok;
    logic                 w_we;
    logic [ADDR_BITS-1:0] w_waddr;
    logic                 w_wdata;
    logic                 w_rd_bit;

    // Map index of block (k, a): 2^(ADDR_BITS-k) plus a >> k; the two parts never overlap.
    function automatic logic [ADDR_BITS-1:0] f_index(logic [ORDER_W-1:0] k,
                                                     logic [AW-1:0] a);
        logic [ADDR_BITS-1:0] a_lo;
        logic [ADDR_BITS-1:0] lead;
        a_lo = a[ADDR_BITS-1:0];
        lead = {{(ADDR_BITS-1){1'b0}}, 1'b1} << (ORDER_W'(ADDR_BITS) - k);
        return (a_lo >> k) | lead;
    endfunction

    assign w_bit      = AW'(1) << r_order;
    assign w_buddy    = r_addr ^ w_bit;
    assign w_sel_addr = (r_state == S_PROBE || r_state == S_BUD) ? w_buddy : r_addr;
    assign w_map_idx  = f_index(r_order, w_sel_addr);

    assign w_ok = (r_order != '0)
               && (r_order <= ORDER_W'(TOP_ORDER))
               && ((r_addr & ~({AW{1'b1}} << r_order)) == '0)
               && ((r_addr >> ADDR_BITS) == '0);

    // A buddy found free is cleared in the same cycle its bit is seen.
    assign w_we    = (r_state == S_CLEAR) || (r_state == S_MARK)
                  || (r_state == S_BUD && w_rd_bit);
    assign w_waddr = (r_state == S_CLEAR) ? r_clr_cnt : w_map_idx;
    assign w_wdata = (r_state == S_MARK);

    bbrm_ram #(
        .WIDTH (1),
        .DEPTH (1 << ADDR_BITS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_map_idx),
        .o_rdata (w_rd_bit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_cnt <= '0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_clr_cnt <= r_clr_cnt + 1'b1;
                    if (&r_clr_cnt) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_op    <= i_req.operation;
                        r_order <= i_req.order;
                        r_addr  <= AW'(i_req.start_address);
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (!w_ok) begin
                        r_status <= ST_BAD;
                        r_bf     <= 1'b0;
                        r_state  <= S_OUT;
                    end else begin
                        r_state <= S_OWN;
                    end
                end
                S_OWN: begin
                    if (r_op inside {OP_LOAD, OP_RELEASE}) begin
                        if (w_rd_bit) begin
                            r_status <= ST_FREE;
                            r_bf     <= 1'b1;
                            r_state  <= S_OUT;
                        end else if (r_op == OP_LOAD) begin
                            r_state <= S_MARK;
                        end else begin
                            r_state <= S_PROBE;
                        end
                    end else begin
                        // Unused code 3 behaves as a query.
                        r_status <= ST_OK;
                        r_bf     <= w_rd_bit;
                        r_state  <= S_OUT;
                    end
                end
                S_PROBE: begin
                    if (r_order < ORDER_W'(TOP_ORDER)) begin
                        r_state <= S_BUD;
                    end else begin
                        r_state <= S_MARK;
                    end
                end
                S_BUD: begin
                    if (w_rd_bit) begin
                        r_addr  <= r_addr & ~w_bit;
                        r_order <= r_order + 1'b1;
                        r_state <= S_PROBE;
                    end else begin
                        r_state <= S_MARK;
                    end
                end
                S_MARK: begin
                    r_status <= ST_OK;
                    r_bf     <= 1'b1;
                    r_state  <= S_OUT;
                end
                S_OUT: begin
                    if (o_rsp.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = (r_state == S_OUT);
    assign o_rsp.final_order = r_order;
    assign o_rsp.final_start = r_addr[START_W-1:0];
    assign o_rsp.block_free  = r_bf;
    assign o_rsp.status      = r_status;

    `ASSERT_CLK(a_one_side, i_clk, i_rst_n,
        !(i_req.ready && o_rsp.valid), "ready while a response is pending")
    `ASSERT_IMPL(a_busy_after_accept, i_clk, i_rst_n,
        i_req.valid && i_req.ready, ##1 !i_req.ready, "request taken while busy")
    `ASSERT_IMPL(a_order_range, i_clk, i_rst_n,
        o_rsp.valid && o_rsp.status == ST_OK,
        o_rsp.final_order != '0 && o_rsp.final_order <= ORDER_W'(TOP_ORDER),
        "good response order out of range")
    `ASSERT_IMPL(a_free_flag, i_clk, i_rst_n,
        o_rsp.valid && o_rsp.status != ST_OK,
        o_rsp.block_free == (o_rsp.status == ST_FREE), "free flag disagrees with status")

endmodule

FILE: verif/tb.sv
// Testbench for the buddy block release and merge unit: directed and random beats checked live.
`timescale 1ns / 1ps

module tb;
    import bbrm_pkg::*;

    localparam int TOP_ORDER     = 16;
    localparam int ADDR_BITS     = 16;
    localparam int RANDOM_ITEMS  = 700;
    localparam int PHASE_LEN     = 240;
    localparam int HOLD_AT       = 560;
    localparam int HOLD_CYCLES   = 300;
    localparam int TAIL_CYCLES   = 50;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        t_op                op;
        logic [ORDER_W-1:0] order;
        logic [START_W-1:0] start;
    } t_block_req;

    typedef struct packed {
        logic [ORDER_W-1:0] final_order;
        logic [START_W-1:0] final_start;
        logic               block_free;
        t_status            status;
    } t_block_result;

    logic i_clk;
    logic i_rst_n;

    bbrm_req_if req_ch ();
    bbrm_rsp_if rsp_ch ();

    buddy_block_release_merge dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch)
    );

    t_block_req    block_requests[$];
    t_block_result block_outcomes[$];
    bit            free_map[0:(1 << ADDR_BITS) - 1];

    int  total_items;
    int  accepted_count;
    int  mismatch_count;
    int  stray_count;
    int  merge_count;
    int  deepest_merge;
    int  bad_count;
    int  already_free_count;
    bit  hold_rsp;
    bit  req_taken;

    always #4 i_clk = ~i_clk;

    function automatic int map_slot(int k, int s);
        return (1 << (ADDR_BITS - k)) + (s >> k);
    endfunction

    // Mirrors the free map update for one beat and returns the response it must give.
    function automatic t_block_result coalesce_block(t_block_req rq);
        t_block_result r;
        int  k;
        int  s;
        bit  ok;
        k = rq.order;
        s = rq.start;
        ok = (k >= 1) && (k <= TOP_ORDER);
        if (ok && ((s & ((1 << k) - 1)) != 0))
            ok = 0;
        r.final_order = rq.order;
        r.final_start = rq.start;
        r.block_free  = 1'b0;
        r.status      = ST_OK;
        if (!ok) begin
            r.status = ST_BAD;
        end else if (rq.op == OP_LOAD || rq.op == OP_RELEASE) begin
            if (free_map[map_slot(k, s)]) begin
                r.status     = ST_FREE;
                r.block_free = 1'b1;
            end else begin
                if (rq.op == OP_RELEASE) begin
                    while (k < TOP_ORDER && free_map[map_slot(k, s ^ (1 << k))]) begin
                        free_map[map_slot(k, s ^ (1 << k))] = 1'b0;
                        s = s & ~(1 << k);
                        k++;
                    end
                end
                free_map[map_slot(k, s)] = 1'b1;
                r.block_free  = 1'b1;
                r.final_order = k[ORDER_W-1:0];
                r.final_start = s[START_W-1:0];
            end
        end else begin
            // Query, and the unused code, read the bit without touching the map.
            r.block_free = free_map[map_slot(k, s)];
        end
        return r;
    endfunction

    function automatic void add_req(t_op op, int k, int s);
        t_block_req rq;
        rq.op    = op;
        rq.order = k[ORDER_W-1:0];
        rq.start = s[START_W-1:0];
        block_requests.push_back(rq);
        total_items++;
    endfunction

    function automatic int send_idle_pct();
        if (accepted_count < PHASE_LEN)
            return 11;
        else if (accepted_count < 2 * PHASE_LEN)
            return 75;
        return 0;
    endfunction

    function automatic int recv_idle_pct();
        if (accepted_count < PHASE_LEN)
            return 75;
        else if (accepted_count < 2 * PHASE_LEN)
            return 11;
        return 0;
    endfunction

    // Request driver.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!req_ch.valid || req_taken) begin
                if (block_requests.size() > 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
                    t_block_req rq;
                    rq = block_requests.pop_front();
                    req_ch.valid         <= 1'b1;
                    req_ch.operation     <= rq.op;
                    req_ch.order         <= rq.order;
                    req_ch.start_address <= rq.start;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
            rsp_ch.ready <= !hold_rsp && ($urandom_range(0, 99) >= recv_idle_pct());
        end
    end

    // Request and response monitor.
    always @(posedge i_clk) begin
        req_taken <= req_ch.valid && req_ch.ready;
        if (i_rst_n && req_ch.valid && req_ch.ready) begin
            t_block_req    rq;
            t_block_result r;
            rq.op    = req_ch.operation;
            rq.order = req_ch.order;
            rq.start = req_ch.start_address;
            r = coalesce_block(rq);
            if (rq.op == OP_RELEASE && r.status == ST_OK && r.final_order != rq.order) begin
                merge_count++;
                if (r.final_order - rq.order > deepest_merge)
                    deepest_merge = r.final_order - rq.order;
            end
            if (r.status == ST_BAD)
                bad_count++;
            if (r.status == ST_FREE)
                already_free_count++;
            block_outcomes.push_back(r);
            accepted_count++;
        end
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            t_block_result got;
            t_block_result want;
            got.final_order = rsp_ch.final_order;
            got.final_start = rsp_ch.final_start;
            got.block_free  = rsp_ch.block_free;
            got.status      = rsp_ch.status;
            if (block_outcomes.size() == 0) begin
                stray_count++;
                $display("unexpected response beat: order %0d start %h free %b status %0d",
                         got.final_order, got.final_start, got.block_free, got.status);
            end else begin
                want = block_outcomes.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display({"mismatch: order %0d/%0d start %h/%h free %b/%b ",
                                  "status %0d/%0d (expected/actual)"},
                                 want.final_order, got.final_order,
                                 want.final_start, got.final_start,
                                 want.block_free, got.block_free,
                                 want.status, got.status);
                end
            end
        end
    end

    // Long response stall while the sender keeps offering beats.
    initial begin
        hold_rsp = 1'b0;
        wait (accepted_count >= HOLD_AT);
        @(posedge i_clk);
        hold_rsp = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_rsp = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int n;
        int base;
        int len;
        int roll;
        int k;
        int s;
        t_op op;

        i_clk                = 1'b0;
        i_rst_n              = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.operation     = OP_LOAD;
        req_ch.order         = '0;
        req_ch.start_address = '0;
        rsp_ch.ready         = 1'b0;
        req_taken            = 1'b0;
        foreach (free_map[i])
            free_map[i] = 1'b0;

        // Buddies at every order below the top, then one release that climbs all the way.
        for (k = 1; k < TOP_ORDER; k++)
            add_req(OP_LOAD, k, 1 << k);
        add_req(OP_RELEASE, 1, 0);
        add_req(OP_RELEASE, TOP_ORDER, 0);
        add_req(t_op'(2'd3), TOP_ORDER, 0);
        add_req(OP_LOAD, 3, 1);
        add_req(OP_RELEASE, 0, 0);
        add_req(OP_QUERY, 31, 16'hFFFF);
        add_req(OP_LOAD, 17, 0);
        add_req(OP_LOAD, 1, 16'hFFFE);
        add_req(OP_RELEASE, 1, 16'hFFFC);
        add_req(OP_QUERY, 1, 16'hFFFE);

        // Random part: short bursts mostly in one 64-unit window so buddies meet; some beats go anywhere.
        n = 0;
        while (n < RANDOM_ITEMS) begin
            base = $urandom_range(0, 1023) << 6;
            len  = $urandom_range(8, 16);
            repeat (len) begin
                roll = $urandom_range(0, 99);
                if (roll < 6) begin
                    op = t_op'($urandom_range(0, 3));
                    k  = $urandom_range(0, 31);
                    s  = $urandom_range(0, 65535);
                end else begin
                    if (roll < 12) begin
                        k = $urandom_range(5, TOP_ORDER);
                        s = $urandom_range(0, 65535) & ~((1 << k) - 1);
                    end else begin
                        k = $urandom_range(1, 5);
                        s = base | ($urandom_range(0, 63) & ~((1 << k) - 1));
                    end
                    roll = $urandom_range(0, 99);
                    op = (roll < 60) ? OP_RELEASE : (roll < 80) ? OP_LOAD : OP_QUERY;
                    if ($urandom_range(0, 99) < 4)
                        s = s ^ (1 << $urandom_range(0, k - 1));
                end
                add_req(op, k, s);
                n++;
            end
        end

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait (accepted_count == total_items);
        wait (block_outcomes.size() == 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d beats: %0d merging releases (deepest %0d orders)",
                 accepted_count, merge_count, deepest_merge);
        $display("rejected blocks %0d, already free %0d, mismatches %0d, stray responses %0d",
                 bad_count, already_free_count, mismatch_count, stray_count);
        if (mismatch_count == 0 && stray_count == 0 && block_outcomes.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
